// ===== sv/refcounted_lru_block_cache_tags_assert.svh =====
// Assertion macros used by the buffer cache tag manager checker.
`ifndef REFCOUNTED_LRU_BLOCK_CACHE_TAGS_ASSERT_SVH
`define REFCOUNTED_LRU_BLOCK_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RLRU_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define RLRU_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rlru_pkg.sv =====
// Package: types, codes and defaults of the buffer cache tag manager.
`default_nettype none
package rlru_pkg;

  // Default number of buffer slots
  localparam int SLOT_COUNT_DEF = 32;

  // Command codes
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_COUNT  = 2'd2;

  // Saturation point of a reference count
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // One slot's tag, valid mark and reference count
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic        valid;
    logic [7:0]  count;
  } entry_t;

  // What the shared scan unit has found so far
  typedef struct packed {
    logic hit_found;
    logic vic_found;
  } scan_flags_t;

  // Operating mode of the shared scan unit
  typedef enum logic {
    MODE_SEARCH = 1'b0,
    MODE_FRONT  = 1'b1
  } scan_mode_t;

endpackage
`default_nettype wire

// ===== sv/rlru_entry_ram.sv =====
// Slot memory: tags, valid marks, counts and recency ranks, one port each way.
`default_nettype none
module rlru_entry_ram #(
  parameter int SLOT_COUNT = rlru_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          ent_we,
  input  logic                          rank_we,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  rlru_pkg::entry_t              wr_entry,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_rank,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output rlru_pkg::entry_t              rd_entry,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_rank
);
  import rlru_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);

  entry_t        ent_mem  [SLOT_COUNT];
  logic [IW-1:0] rank_mem [SLOT_COUNT];

  // Write one slot
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[wr_addr] <= wr_entry;
    end
    if (rank_we) begin
      rank_mem[wr_addr] <= wr_rank;
    end
  end

  // Read one slot, data registered
  always_ff @(posedge clk) begin
    rd_entry <= ent_mem[rd_addr];
    rd_rank  <= rank_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/rlru_scan_unit.sv =====
// Shared scan unit: one rank comparator that picks hit and victim, or ages ranks.
`default_nettype none
module rlru_scan_unit #(
  parameter int SLOT_COUNT = rlru_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          step,
  input  rlru_pkg::scan_mode_t          mode,
  input  logic [$clog2(SLOT_COUNT)-1:0] index,
  input  rlru_pkg::entry_t              entry,
  input  logic [$clog2(SLOT_COUNT)-1:0] rank,
  input  logic [7:0]                    key_dev,
  input  logic [31:0]                   key_blk,
  input  logic [$clog2(SLOT_COUNT)-1:0] front_slot,
  input  logic [$clog2(SLOT_COUNT)-1:0] front_rank,
  output rlru_pkg::scan_flags_t         flags,
  output logic [$clog2(SLOT_COUNT)-1:0] hit_idx,
  output rlru_pkg::entry_t              hit_entry,
  output logic [$clog2(SLOT_COUNT)-1:0] vic_idx,
  output logic [$clog2(SLOT_COUNT)-1:0] new_rank
);
  import rlru_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);

  logic [IW-1:0] hit_rank;
  logic [IW-1:0] vic_rank;
  logic [IW-1:0] cmp_a;
  logic [IW-1:0] cmp_b;
  logic          cmp_lt;
  logic          match;

  assign match = (entry.dev == key_dev) && (entry.blk == key_blk);

  // Steer the single comparator: hit wants a lower rank, victim a higher one
  always_comb begin
    case (mode)
      MODE_SEARCH: begin
        if (match) begin
          cmp_a = rank;
          cmp_b = hit_rank;
        end else begin
          cmp_a = vic_rank;
          cmp_b = rank;
        end
      end
      MODE_FRONT: begin
        cmp_a = rank;
        cmp_b = front_rank;
      end
      default: begin
        cmp_a = rank;
        cmp_b = front_rank;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Age ranks newer than the released slot; the released slot becomes newest
  assign new_rank = (index == front_slot) ? '0 : (cmp_lt ? rank + IW'(1) : rank);

  // Track the newest matching slot and the oldest free slot
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags.hit_found <= 1'b0;
      flags.vic_found <= 1'b0;
    end else if (step && mode == MODE_SEARCH) begin
      if (match) begin
        if (!flags.hit_found || cmp_lt) begin
          flags.hit_found <= 1'b1;
          hit_idx         <= index;
          hit_rank        <= rank;
          hit_entry       <= entry;
        end
      end else if (entry.count == 8'd0) begin
        if (!flags.vic_found || cmp_lt) begin
          flags.vic_found <= 1'b1;
          vic_idx         <= index;
          vic_rank        <= rank;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/refcounted_lru_block_cache_tags.sv =====
// Top level: sequencer of the reference-counted LRU buffer cache tag manager.
// One item is handled at a time. A read walks every slot once through the slot
// memory's single read port and the shared rank comparator, then goes through
// S_DECIDE to S_PUT. A release that drops a count to zero makes a walk to age
// the ranks in S_FRONT; other release, pin and unpin items pass S_FETCH and
// S_CHECK, and an out-of-range slot goes straight to S_PUT.
// A result waiting on a stalled output holds the sequencer until it is taken.
// After reset a clearing pass writes every slot (tags zero, slot i at rank
// SLOT_COUNT-1-i) while input stays stalled.
`default_nettype none
module refcounted_lru_block_cache_tags #(
  parameter int SLOT_COUNT = rlru_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  slot_out,
  output logic        need_read,
  output logic [1:0]  status
);
  import rlru_pkg::*;

  localparam int            IW        = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOT_COUNT - 1);
  localparam logic [IW:0]   IDX_END   = (IW + 1)'(SLOT_COUNT);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_FETCH  = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_FRONT  = 8'b0100_0000,
    S_PUT    = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [IW:0]   idx;
  logic [1:0]    cmd;
  logic [7:0]    key_dev;
  logic [31:0]   key_blk;
  logic [4:0]    key_slot;
  logic [IW-1:0] front_rank;
  logic [4:0]    res_slot;
  logic          res_nr;
  logic [1:0]    res_status;

  logic [IW-1:0] s_idx;
  logic [IW-1:0] prev_idx;
  logic          ent_we;
  logic          rank_we;
  logic [IW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [IW-1:0] wr_rank;
  logic [IW-1:0] rd_addr;
  entry_t        rd_entry;
  logic [IW-1:0] rd_rank;

  scan_flags_t   flags;
  logic [IW-1:0] hit_idx;
  entry_t        hit_entry;
  logic [IW-1:0] vic_idx;
  logic [IW-1:0] new_rank;
  scan_mode_t    mode;
  logic          step;
  logic          out_free;

  assign s_idx    = IW'(key_slot);
  assign prev_idx = IW'(idx - (IW + 1)'(1));
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rd_addr  = (state == S_FETCH) ? s_idx : idx[IW-1:0];
  assign mode     = (state == S_FRONT) ? MODE_FRONT : MODE_SEARCH;
  assign step     = (state == S_SCAN) && (idx != '0);

  rlru_entry_ram #(.SLOT_COUNT(SLOT_COUNT)) u_ram (
    .clk      (clk),
    .ent_we   (ent_we),
    .rank_we  (rank_we),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .wr_rank  (wr_rank),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_rank  (rd_rank)
  );

  rlru_scan_unit #(.SLOT_COUNT(SLOT_COUNT)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (state == S_IDLE),
    .step       (step),
    .mode       (mode),
    .index      (prev_idx),
    .entry      (rd_entry),
    .rank       (rd_rank),
    .key_dev    (key_dev),
    .key_blk    (key_blk),
    .front_slot (s_idx),
    .front_rank (front_rank),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .hit_entry  (hit_entry),
    .vic_idx    (vic_idx),
    .new_rank   (new_rank)
  );

  // Drive the slot memory write port
  always_comb begin
    ent_we   = 1'b0;
    rank_we  = 1'b0;
    wr_addr  = idx[IW-1:0];
    wr_entry = '0;
    wr_rank  = '0;
    case (state)
      S_CLEAR: begin
        ent_we  = 1'b1;
        rank_we = 1'b1;
        wr_rank = LAST_IDX - idx[IW-1:0];
      end
      S_DECIDE: begin
        if (flags.hit_found) begin
          wr_addr        = hit_idx;
          wr_entry       = hit_entry;
          wr_entry.valid = 1'b1;
          wr_entry.count = hit_entry.count + 8'd1;
          ent_we         = (hit_entry.count != COUNT_MAX);
        end else begin
          wr_addr  = vic_idx;
          wr_entry = '{dev: key_dev, blk: key_blk, valid: 1'b1, count: 8'd1};
          ent_we   = flags.vic_found;
        end
      end
      S_CHECK: begin
        wr_addr  = s_idx;
        wr_entry = rd_entry;
        if (cmd == CMD_PIN) begin
          wr_entry.count = rd_entry.count + 8'd1;
          ent_we         = (rd_entry.count != COUNT_MAX);
        end else begin
          wr_entry.count = rd_entry.count - 8'd1;
          ent_we         = (rd_entry.count != 8'd0);
        end
      end
      S_FRONT: begin
        wr_addr = prev_idx;
        wr_rank = new_rank;
        rank_we = (idx != '0);
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end

  // Sequence one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx + (IW + 1)'(1);
          if (idx[IW-1:0] == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd      <= command;
            key_dev  <= device;
            key_blk  <= block_number;
            key_slot <= slot;
            idx      <= '0;
            if (command == CMD_READ) begin
              state <= S_SCAN;
            end else if (int'(slot) >= SLOT_COUNT) begin
              res_slot   <= slot;
              res_nr     <= 1'b0;
              res_status <= ST_COUNT;
              state      <= S_PUT;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + (IW + 1)'(1);
          if (idx == IDX_END) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_nr <= 1'b0;
          if (flags.hit_found) begin
            res_slot <= 5'(hit_idx);
            if (hit_entry.count == COUNT_MAX) begin
              res_status <= ST_COUNT;
            end else begin
              res_status <= ST_OK;
              res_nr     <= !hit_entry.valid;
            end
          end else if (flags.vic_found) begin
            res_slot   <= 5'(vic_idx);
            res_nr     <= 1'b1;
            res_status <= ST_OK;
          end else begin
            res_slot   <= '0;
            res_status <= ST_NOFREE;
          end
          state <= S_PUT;
        end
        S_FETCH: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_slot <= key_slot;
          res_nr   <= 1'b0;
          state    <= S_PUT;
          if (cmd == CMD_PIN) begin
            res_status <= (rd_entry.count == COUNT_MAX) ? ST_COUNT : ST_OK;
          end else if (rd_entry.count == 8'd0) begin
            res_status <= ST_COUNT;
          end else begin
            res_status <= ST_OK;
            // Last reference dropped by release: move the slot to newest
            if (cmd == CMD_RELEASE && rd_entry.count == 8'd1) begin
              front_rank <= rd_rank;
              idx        <= '0;
              state      <= S_FRONT;
            end
          end
        end
        S_FRONT: begin
          idx <= idx + (IW + 1)'(1);
          if (idx == IDX_END) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          idx   <= '0;
        end
      endcase
    end
  end

  // Output register: drop when taken, load when the result is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_PUT && out_free) begin
        out_valid <= 1'b1;
        slot_out  <= res_slot;
        need_read <= res_nr;
        status    <= res_status;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/rlru_checker.sv =====
// Port checker for the buffer cache tag manager, bound to the top level.
`default_nettype none
`include "refcounted_lru_block_cache_tags_assert.svh"
module rlru_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] slot_out,
  input wire logic       need_read,
  input wire logic [1:0] status
);
  import rlru_pkg::*;

  // One item at a time: an accepted item stalls the input next cycle
  `RLRU_ASSERT_NXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "item overlap")

  // A stalled result holds
  `RLRU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(slot_out) && $stable(need_read) && $stable(status), "result moved")

  // Errors never ask for a disk read
  `RLRU_ASSERT_IMP(a_err_no_read, clk, rst, out_valid && status != ST_OK, !need_read, "read on error")

  // No free buffer reports slot zero, and status is a known code
  `RLRU_ASSERT_IMP(a_nofree_slot, clk, rst, out_valid && status == ST_NOFREE,
    slot_out == 5'd0, "nofree slot")
  `RLRU_ASSERT_IMP(a_status_code, clk, rst, out_valid,
    status == ST_OK || status == ST_NOFREE || status == ST_COUNT, "bad status")

endmodule

bind refcounted_lru_block_cache_tags rlru_checker u_rlru_checker (.*);
`default_nettype wire
